@@ sv/aarm_pkg.sv @@
// ---------------------------------------------------------------------------
// aarm_pkg: shared constants, types and tables for the axis-angle rotation
// matrix unit (CORDIC constants, arctangent table, entry ordering).
// ---------------------------------------------------------------------------
package aarm_pkg;

    // Default number of fraction bits for the matrix arithmetic
    localparam int FRAC_BITS_DEF = 16;

    // CORDIC format and depth
    localparam int CORDIC_FRAC  = 30;
    localparam int CORDIC_ITERS = 30;
    localparam int ANG_W        = 36;   // scaled input angle before reduction
    localparam int CRD_W        = 34;   // CORDIC x, y and residual angle

    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [CRD_W-1:0] GAIN_Q30    = 34'sd652032874;

    // Matrix entries per item
    localparam int N_ENTRIES   = 16;
    localparam int MAT_ENTRIES = 9;
    localparam logic [3:0] LAST_IDX = 4'(N_ENTRIES - 1);

    // Constant 1.0 in s15.16
    localparam logic [31:0] ENTRY_ONE  = 32'h0001_0000;
    localparam logic [31:0] ENTRY_ZERO = 32'h0000_0000;

    // Kind of a result entry
    typedef enum logic [1:0] {
        ENT_MAT  = 2'd0,
        ENT_ZERO = 2'd1,
        ENT_ONE  = 2'd2
    } ent_kind_t;

    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
        ent_kind_t  kind;
    } ent_pos_t;

    // Arctangent of 2^-n, Q30
    function automatic logic signed [CRD_W-1:0] atan_q30(input int n);
        logic signed [CRD_W-1:0] r;
        case (n)
            0:  r = 34'sd843314857;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043836;
            3:  r = 34'sd133525158;
            4:  r = 34'sd67021686;
            5:  r = 34'sd33543515;
            6:  r = 34'sd16775850;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194282;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048575;
            11: r = 34'sd524287;
            12: r = 34'sd262143;
            13: r = 34'sd131071;
            14: r = 34'sd65535;
            15: r = 34'sd32767;
            16: r = 34'sd16383;
            17: r = 34'sd8191;
            18: r = 34'sd4095;
            19: r = 34'sd2047;
            20: r = 34'sd1023;
            21: r = 34'sd511;
            22: r = 34'sd255;
            23: r = 34'sd127;
            24: r = 34'sd63;
            25: r = 34'sd31;
            26: r = 34'sd15;
            27: r = 34'sd8;
            28: r = 34'sd4;
            29: r = 34'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Position and kind of the n-th result entry (untransposed)
    function automatic ent_pos_t entry_pos(input logic [3:0] idx);
        ent_pos_t p;
        case (idx)
            4'd0:  p = '{row: 2'd0, col: 2'd0, kind: ENT_MAT};
            4'd1:  p = '{row: 2'd0, col: 2'd1, kind: ENT_MAT};
            4'd2:  p = '{row: 2'd0, col: 2'd2, kind: ENT_MAT};
            4'd3:  p = '{row: 2'd1, col: 2'd0, kind: ENT_MAT};
            4'd4:  p = '{row: 2'd1, col: 2'd1, kind: ENT_MAT};
            4'd5:  p = '{row: 2'd1, col: 2'd2, kind: ENT_MAT};
            4'd6:  p = '{row: 2'd2, col: 2'd0, kind: ENT_MAT};
            4'd7:  p = '{row: 2'd2, col: 2'd1, kind: ENT_MAT};
            4'd8:  p = '{row: 2'd2, col: 2'd2, kind: ENT_MAT};
            4'd9:  p = '{row: 2'd3, col: 2'd0, kind: ENT_ZERO};
            4'd10: p = '{row: 2'd0, col: 2'd3, kind: ENT_ZERO};
            4'd11: p = '{row: 2'd3, col: 2'd1, kind: ENT_ZERO};
            4'd12: p = '{row: 2'd1, col: 2'd3, kind: ENT_ZERO};
            4'd13: p = '{row: 2'd3, col: 2'd2, kind: ENT_ZERO};
            4'd14: p = '{row: 2'd2, col: 2'd3, kind: ENT_ZERO};
            default: p = '{row: 2'd3, col: 2'd3, kind: ENT_ONE};
        endcase
        return p;
    endfunction

endpackage

@@ sv/axis_angle_rotation_matrix_unit.sv @@
// ---------------------------------------------------------------------------
// axis_angle_rotation_matrix_unit: 4x4 homogeneous rotation matrix builder
//
// Takes a unit axis, an angle in radians and a transpose flag per request and
// returns the sixteen s15.16 entries of the rotation matrix, one entry per
// cycle while m_ready is high: the 3x3 part row by row (swapped when
// transposed), then the zero entries of row 3 and column 3, and finally the
// 1.0 corner with last set. Sine and cosine come from a fully pipelined
// 30-stage CORDIC; the whole datapath is 35 register stages deep, followed
// by the serialiser register. A new matrix starts once the last entry of
// the previous one is taken. Up to 35 further requests are taken into the
// pipeline while an earlier matrix is being sent.
// ---------------------------------------------------------------------------
module axis_angle_rotation_matrix_unit #(
    parameter int FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [17:0] s_axis_x,
    input  logic signed [17:0] s_axis_y,
    input  logic signed [17:0] s_axis_z,
    input  logic signed [19:0] s_angle,
    input  logic               s_transposed,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_row,
    output logic [1:0]         m_col,
    output logic signed [15:0] m_int_part,
    output logic [15:0]        m_frac_part,
    output logic               m_last
);
    import aarm_pkg::*;

    // Derived widths
    localparam int F    = FRAC_BITS;
    localparam int CI   = CORDIC_ITERS;
    localparam int NST  = CI + 5;               // pipeline stages before output
    localparam int AW   = F + 2;                // axis component
    localparam int SW   = F + 2;                // sine / cosine
    localparam int OW   = F + 3;                // one minus cosine
    localparam int PW   = F + 4;                // first-level products
    localparam int QW   = F + 7;                // product with one minus cosine
    localparam int VW   = F + 8;                // entry sum
    localparam int LSA  = (F >= 16) ? F - 16 : 0;
    localparam int RSA  = (F < 16) ? 16 - F : 0;
    localparam int XAW  = 18 + LSA;
    localparam int CSH  = CORDIC_FRAC - F;
    localparam int RS   = (F > 16) ? F - 16 : 0;
    localparam int LS   = (F < 16) ? 16 - F : 0;
    localparam int EW   = VW + LS + 1;
    localparam logic signed [VW-1:0] RND = (F > 16) ? VW'(1) <<< (F - 17) : '0;
    localparam logic signed [OW-1:0] ONE_F = OW'(1) <<< F;

    typedef struct packed {
        logic signed [AW-1:0] ax;
        logic signed [AW-1:0] ay;
        logic signed [AW-1:0] az;
        logic                 tr;
        logic                 negc;
    } side_t;

    // Stage control
    logic [NST-1:0] vld_reg, vld_next;
    logic [NST:0]   load;
    logic           ser_vld_reg, ser_vld_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic           ser_free;

    // Stage data
    logic signed [ANG_W-1:0] ang0_reg, ang0_next;
    side_t                   side_reg [0:CI+1];
    side_t                   side0_next;
    side_t                   side1_next;
    logic signed [CRD_W-1:0] cx_reg [0:CI];
    logic signed [CRD_W-1:0] cy_reg [0:CI];
    logic signed [CRD_W-1:0] cz_reg [0:CI];
    logic signed [CRD_W-1:0] fold_next;
    logic                    negc_next;

    logic signed [PW-1:0] aa_reg [0:MAT_ENTRIES-1];
    logic signed [PW-1:0] aa_next [0:MAT_ENTRIES-1];
    logic signed [PW-1:0] sa_reg [0:2];
    logic signed [PW-1:0] sa_next [0:2];
    logic signed [SW-1:0] c32_reg, c32_next;
    logic signed [OW-1:0] omc_reg, omc_next;
    logic                 tr32_reg;

    logic signed [QW-1:0] pv_reg [0:MAT_ENTRIES-1];
    logic signed [QW-1:0] pv_next [0:MAT_ENTRIES-1];
    logic signed [PW-1:0] sa33_reg [0:2];
    logic signed [SW-1:0] c33_reg;
    logic                 tr33_reg;

    logic [31:0] ent_reg [0:MAT_ENTRIES-1];
    logic [31:0] ent_next [0:MAT_ENTRIES-1];
    logic        tr34_reg;

    logic [31:0] ser_ent_reg [0:MAT_ENTRIES-1];
    logic        ser_tr_reg;

    // Output mux signals
    ent_pos_t    pos;
    logic [31:0] out_ent;

    // Serialiser can take a new matrix when empty or when its last entry is taken
    assign ser_free = !ser_vld_reg || (m_ready && cnt_reg == LAST_IDX);

    // A stage loads when empty or when the whole pipe advances
    always_comb begin
        load[NST] = ser_free;
        for (int k = 0; k < NST; k++) begin
            load[k] = ser_free || !vld_reg[k];
        end
    end

    assign s_ready = load[0];

    // Advance valid bits; a stage that hands its request on without reloading empties
    always_comb begin
        vld_next[0] = load[0] ? s_valid : (load[1] ? 1'b0 : vld_reg[0]);
        for (int k = 1; k < NST; k++) begin
            vld_next[k] = load[k] ? vld_reg[k-1] : (load[k+1] ? 1'b0 : vld_reg[k]);
        end
    end

    // Serialiser control
    always_comb begin
        ser_vld_next = ser_vld_reg;
        cnt_next     = cnt_reg;
        if (ser_free) begin
            ser_vld_next = vld_reg[NST-1];
            cnt_next     = '0;
        end else if (m_ready) begin
            cnt_next = cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            ser_vld_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            vld_reg     <= vld_next;
            ser_vld_reg <= ser_vld_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Stage 0: scale angle to Q30, reduce into [-pi, pi], rescale the axis
    always_comb begin
        logic signed [ANG_W-1:0] a_in;
        logic signed [XAW-1:0]   wx, wy, wz;
        a_in = ANG_W'(s_angle) <<< (CORDIC_FRAC - 16);
        if (a_in > PI_Q30) begin
            ang0_next = a_in - TWO_PI_Q30;
        end else if (a_in < -PI_Q30) begin
            ang0_next = a_in + TWO_PI_Q30;
        end else begin
            ang0_next = a_in;
        end
        wx = (XAW'(s_axis_x) <<< LSA) >>> RSA;
        wy = (XAW'(s_axis_y) <<< LSA) >>> RSA;
        wz = (XAW'(s_axis_z) <<< LSA) >>> RSA;
        side0_next.ax   = AW'(wx);
        side0_next.ay   = AW'(wy);
        side0_next.az   = AW'(wz);
        side0_next.tr   = s_transposed;
        side0_next.negc = 1'b0;
    end

    // Stage 1: fold into [-pi/2, pi/2], noting that cosine flips sign
    always_comb begin
        if (ang0_reg > HALF_PI_Q30) begin
            fold_next = CRD_W'(PI_Q30 - ang0_reg);
            negc_next = 1'b1;
        end else if (ang0_reg < -HALF_PI_Q30) begin
            fold_next = CRD_W'(-PI_Q30 - ang0_reg);
            negc_next = 1'b1;
        end else begin
            fold_next = CRD_W'(ang0_reg);
            negc_next = 1'b0;
        end
        side1_next      = side_reg[0];
        side1_next.negc = negc_next;
    end

    // Stages 0 to 31: angle path, CORDIC iterations and side data
    always_ff @(posedge aclk) begin
        if (load[0]) begin
            ang0_reg    <= ang0_next;
            side_reg[0] <= side0_next;
        end
        if (load[1]) begin
            cx_reg[0]   <= GAIN_Q30;
            cy_reg[0]   <= '0;
            cz_reg[0]   <= fold_next;
            side_reg[1] <= side1_next;
        end
        for (int n = 0; n < CI; n++) begin
            if (load[n+2]) begin
                side_reg[n+2] <= side_reg[n+1];
                if (!cz_reg[n][CRD_W-1]) begin
                    cx_reg[n+1] <= cx_reg[n] - (cy_reg[n] >>> n);
                    cy_reg[n+1] <= cy_reg[n] + (cx_reg[n] >>> n);
                    cz_reg[n+1] <= cz_reg[n] - atan_q30(n);
                end else begin
                    cx_reg[n+1] <= cx_reg[n] + (cy_reg[n] >>> n);
                    cy_reg[n+1] <= cy_reg[n] - (cx_reg[n] >>> n);
                    cz_reg[n+1] <= cz_reg[n] + atan_q30(n);
                end
            end
        end
    end

    // Stage 32: sine, cosine, axis products and sine-axis products
    always_comb begin
        logic signed [CRD_W-1:0] cn;
        logic signed [SW-1:0]    s_v;
        logic signed [AW-1:0]    av [0:2];
        logic signed [2*AW-1:0]  p2;
        logic signed [SW+AW-1:0] ps;
        s_v      = SW'(cy_reg[CI] >>> CSH);
        cn       = side_reg[CI+1].negc ? -cx_reg[CI] : cx_reg[CI];
        c32_next = SW'(cn >>> CSH);
        omc_next = ONE_F - OW'(c32_next);
        av[0]    = side_reg[CI+1].ax;
        av[1]    = side_reg[CI+1].ay;
        av[2]    = side_reg[CI+1].az;
        for (int e = 0; e < MAT_ENTRIES; e++) begin
            p2         = (2*AW)'(av[e / 3]) * (2*AW)'(av[e % 3]);
            aa_next[e] = PW'(p2 >>> F);
        end
        for (int k = 0; k < 3; k++) begin
            ps         = (SW+AW)'(s_v) * (SW+AW)'(av[k]);
            sa_next[k] = PW'(ps >>> F);
        end
    end

    // Stage 33: multiply by one minus cosine
    always_comb begin
        logic signed [PW+OW-1:0] pq;
        for (int e = 0; e < MAT_ENTRIES; e++) begin
            pq         = (PW+OW)'(aa_reg[e]) * (PW+OW)'(omc_reg);
            pv_next[e] = QW'(pq >>> F);
        end
    end

    // Stage 34: add cosine or the signed sine term, convert to s15.16
    always_comb begin
        logic signed [VW-1:0] v;
        logic signed [EW-1:0] r;
        for (int e = 0; e < MAT_ENTRIES; e++) begin
            if (e / 3 == e % 3) begin
                v = VW'(pv_reg[e]) + VW'(c33_reg);
            end else if ((4 + e % 3 - e / 3) % 3 == 2) begin
                v = VW'(pv_reg[e]) + VW'(sa33_reg[(6 - e / 3 - e % 3) % 3]);
            end else begin
                v = VW'(pv_reg[e]) - VW'(sa33_reg[(6 - e / 3 - e % 3) % 3]);
            end
            // Range of v keeps the result well inside s15.16, no clamp needed
            r           = (EW'(v + RND) >>> RS) <<< LS;
            ent_next[e] = 32'(r);
        end
    end

    // Stages 32 to 34 and the serialiser load
    always_ff @(posedge aclk) begin
        if (load[CI+2]) begin
            aa_reg   <= aa_next;
            sa_reg   <= sa_next;
            c32_reg  <= c32_next;
            omc_reg  <= omc_next;
            tr32_reg <= side_reg[CI+1].tr;
        end
        if (load[CI+3]) begin
            pv_reg   <= pv_next;
            sa33_reg <= sa_reg;
            c33_reg  <= c32_reg;
            tr33_reg <= tr32_reg;
        end
        if (load[CI+4]) begin
            ent_reg  <= ent_next;
            tr34_reg <= tr33_reg;
        end
        if (ser_free) begin
            ser_ent_reg <= ent_reg;
            ser_tr_reg  <= tr34_reg;
        end
    end

    // Select the current entry
    always_comb begin
        pos = entry_pos(cnt_reg);
        case (pos.kind)
            ENT_MAT:  out_ent = ser_ent_reg[cnt_reg];
            ENT_ONE:  out_ent = ENTRY_ONE;
            default:  out_ent = ENTRY_ZERO;
        endcase
        if (pos.kind == ENT_MAT && ser_tr_reg) begin
            m_row = pos.col;
            m_col = pos.row;
        end else begin
            m_row = pos.row;
            m_col = pos.col;
        end
    end

    assign m_valid     = ser_vld_reg;
    assign m_int_part  = out_ent[31:16];
    assign m_frac_part = out_ent[15:0];
    assign m_last      = (cnt_reg == LAST_IDX);

`ifndef NO_ASSERTIONS
    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_row == 2'd3 && m_col == 2'd3)
        else $error("last entry not at the corner");

    a_new_matrix_first: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_free && vld_reg[NST-1] |=> m_valid && cnt_reg == '0)
        else $error("new matrix does not start at entry zero");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(cnt_reg))
        else $error("entry index moved during a stall");

    a_busy_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> ser_vld_reg && vld_reg[0])
        else $error("request refused while pipeline could take it");
`endif

endmodule

@@ tb/axis_angle_rotation_matrix_unit_tb.sv @@
// ---------------------------------------------------------------------------
// axis_angle_rotation_matrix_unit_tb: self-checking bench for the rotation
// matrix unit.
//
// Requests are queued by the stimulus process and driven by a clocked driver.
// Every accepted request is expanded by a local axis-angle/CORDIC predictor
// into its sixteen entries, which a clocked monitor compares in order against
// the result channel under varying idle and back-pressure patterns.
// ---------------------------------------------------------------------------
module axis_angle_rotation_matrix_unit_tb;

    import aarm_pkg::*;

    localparam int FB        = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int SETTLE    = 80;

    typedef struct packed {
        logic signed [17:0] ax;
        logic signed [17:0] ay;
        logic signed [17:0] az;
        logic signed [19:0] ang;
        logic               tr;
    } rot_req_t;

    typedef struct packed {
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [15:0] ip;
        logic [15:0]        fp;
        logic               last;
    } entry_t;

    // Idling modes
    typedef enum int {
        IDLE_NONE = 0,
        IDLE_SRC  = 1,
        IDLE_SNK  = 2,
        IDLE_BOTH = 3
    } idle_mode_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [17:0] s_axis_x = '0;
    logic signed [17:0] s_axis_y = '0;
    logic signed [17:0] s_axis_z = '0;
    logic signed [19:0] s_angle = '0;
    logic               s_transposed = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_row;
    logic [1:0]         m_col;
    logic signed [15:0] m_int_part;
    logic [15:0]        m_frac_part;
    logic               m_last;

    rot_req_t   pending_reqs[$];
    entry_t     expected_entries[$];
    idle_mode_t idle_mode = IDLE_NONE;
    bit         hold_sink = 1'b0;
    bit         stim_done = 1'b0;
    int         fail_count = 0;
    int         quiet_cycles = 0;

    axis_angle_rotation_matrix_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_axis_x(s_axis_x), .s_axis_y(s_axis_y), .s_axis_z(s_axis_z),
        .s_angle(s_angle), .s_transposed(s_transposed),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_row(m_row), .m_col(m_col), .m_int_part(m_int_part),
        .m_frac_part(m_frac_part), .m_last(m_last)
    );

    always #5 aclk = ~aclk;

    function automatic longint floor_div2(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> FB;
    endfunction

    // Rotation-mode CORDIC, result in FB fraction bits
    task automatic cordic_sincos(input longint ang16, output longint sn,
                                 output longint cs);
        longint a, x, y, nx;
        bit     flip;
        a = ang16 <<< 14;
        x = 652032874;
        y = 0;
        flip = 0;
        while (a > 64'sd3373259426) a -= 64'sd6746518852;
        while (a < -64'sd3373259426) a += 64'sd6746518852;
        if (a > 64'sd1686629713) begin
            a = 64'sd3373259426 - a;
            flip = 1;
        end else if (a < -64'sd1686629713) begin
            a = -64'sd3373259426 - a;
            flip = 1;
        end
        for (int i = 0; i < 30; i++) begin
            if (a >= 0) begin
                nx = x - floor_div2(y, i);
                y  = y + floor_div2(x, i);
                a -= longint'(atan_q30(i));
            end else begin
                nx = x + floor_div2(y, i);
                y  = y - floor_div2(x, i);
                a += longint'(atan_q30(i));
            end
            x = nx;
        end
        if (flip) x = -x;
        sn = y >>> 14;
        cs = x >>> 14;
    endtask

    function automatic entry_t make_entry(int r, int c, longint v, bit lst);
        entry_t e;
        logic [31:0] u;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        u = v[31:0];
        e.row = r[1:0];
        e.col = c[1:0];
        e.ip = u[31:16];
        e.fp = u[15:0];
        e.last = lst;
        return e;
    endfunction

    // Expand one accepted request into its sixteen entries
    task automatic predict_matrix(input rot_req_t q);
        longint ax[3], sn, cs, omc, v, t;
        int     sgn, comp;
        ax[0] = q.ax;
        ax[1] = q.ay;
        ax[2] = q.az;
        cordic_sincos(longint'(q.ang), sn, cs);
        omc = (64'sd1 <<< FB) - cs;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                v = qmul(qmul(ax[i], ax[j]), omc);
                if (i == j) begin
                    v += cs;
                end else begin
                    sgn  = ((4 + j - i) % 3) - 1;
                    comp = (6 - i - j) % 3;
                    t = qmul(sn, ax[comp]);
                    v += (sgn > 0) ? t : -t;
                end
                if (q.tr) expected_entries.push_back(make_entry(j, i, v, 0));
                else expected_entries.push_back(make_entry(i, j, v, 0));
            end
        end
        for (int k = 0; k < 3; k++) begin
            expected_entries.push_back(make_entry(3, k, 0, 0));
            expected_entries.push_back(make_entry(k, 3, 0, 0));
        end
        expected_entries.push_back(make_entry(3, 3, 64'sd65536, 1));
    endtask

    function automatic bit coin(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Driver: advance on acceptance, idle at random per mode
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_matrix(pending_reqs.pop_front());
            if (!(s_valid && !s_ready)) begin
                if (pending_reqs.size() > 0 &&
                    !((idle_mode == IDLE_SRC || idle_mode == IDLE_BOTH) &&
                      coin(idle_mode == IDLE_SRC ? 66 : 23))) begin
                    s_valid      <= 1'b1;
                    s_axis_x     <= pending_reqs[0].ax;
                    s_axis_y     <= pending_reqs[0].ay;
                    s_axis_z     <= pending_reqs[0].az;
                    s_angle      <= pending_reqs[0].ang;
                    s_transposed <= pending_reqs[0].tr;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // The pop above runs first in the same block, so index 0 is the next request.

    // Monitor: compare accepted entries, drive ready
    always @(posedge aclk) begin
        entry_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_entries.size() == 0) begin
                    $error("unexpected entry row=%0d col=%0d", m_row, m_col);
                    fail_count++;
                end else begin
                    e = expected_entries.pop_front();
                    if (m_row !== e.row) begin
                        $error("row: expected %0d, got %0d", e.row, m_row);
                        fail_count++;
                    end
                    if (m_col !== e.col) begin
                        $error("col: expected %0d, got %0d", e.col, m_col);
                        fail_count++;
                    end
                    if (m_int_part !== e.ip) begin
                        $error("int_part: expected %0d, got %0d", e.ip, m_int_part);
                        fail_count++;
                    end
                    if (m_frac_part !== e.fp) begin
                        $error("frac_part: expected %0d, got %0d", e.fp, m_frac_part);
                        fail_count++;
                    end
                    if (m_last !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, m_last);
                        fail_count++;
                    end
                end
            end
            if (hold_sink)
                m_ready <= 1'b0;
            else if (idle_mode == IDLE_SNK)
                m_ready <= !coin(66);
            else if (idle_mode == IDLE_BOTH)
                m_ready <= !coin(23);
            else
                m_ready <= 1'b1;
        end
    end

    // Watchdog: count cycles with no acceptance on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic rot_req_t rand_req();
        rot_req_t q;
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) begin
            // Plausible axes: one dominant component, others smaller
            q.ax = 18'($signed($urandom_range(131072)) - 65536);
            q.ay = 18'($signed($urandom_range(65536)) - 32768);
            q.az = 18'($signed($urandom_range(65536)) - 32768);
        end else begin
            // Any bit pattern the fields allow
            q.ax = 18'($urandom);
            q.ay = 18'($urandom);
            q.az = 18'($urandom);
        end
        q.ang = (pick == 9) ? 20'($urandom) :
                20'($signed($urandom_range(823550)) - 411775);
        q.tr = 1'($urandom_range(1));
        return q;
    endfunction

    task automatic add_req(int x, int y, int z, int a, bit t);
        rot_req_t q;
        q.ax = 18'(x);
        q.ay = 18'(y);
        q.az = 18'(z);
        q.ang = 20'(a);
        q.tr = t;
        pending_reqs.push_back(q);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_valid || expected_entries.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: axes, angle extremes, quadrants, transposition, saturation
        add_req(65536, 0, 0, 0, 0);
        add_req(0, 65536, 0, 102944, 0);
        add_req(0, 0, 65536, 205887, 1);
        add_req(0, 0, 65536, -205887, 0);
        add_req(37837, 37837, 37837, 411775, 0);
        add_req(37837, -37837, 37837, -411775, 1);
        add_req(-65536, 0, 0, 154416, 1);
        add_req(0, -65536, 0, -154416, 0);
        add_req(131071, 131071, 131071, 205887, 0);
        add_req(-131072, -131072, -131072, 205887, 1);
        add_req(131071, -131072, 131071, 102944, 0);
        add_req(0, 0, 0, 524287, 1);
        add_req(0, 0, 0, -524288, 0);
        add_req(65536, 65536, 0, 1, 1);
        add_req(-1, -1, -1, -1, 0);
        add_req(46341, 46341, 0, 300000, 1);
        add_req(0, 46341, -46341, -300000, 0);
        add_req(131071, 0, -131072, 411775, 1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            idle_mode = idle_mode_t'(ph);
            for (int n = 0; n < 80; n++) pending_reqs.push_back(rand_req());
            wait_drained();
        end

        // Long back-pressure stretch while requests keep coming
        idle_mode = IDLE_NONE;
        hold_sink = 1'b1;
        for (int n = 0; n < 40; n++) pending_reqs.push_back(rand_req());
        repeat (800) @(posedge aclk);
        hold_sink = 1'b0;
        wait_drained();

        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0 && expected_entries.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ axis_angle_rotation_matrix_unit.f @@
sv/aarm_pkg.sv
sv/axis_angle_rotation_matrix_unit.sv
tb/axis_angle_rotation_matrix_unit_tb.sv
